// ===== src/thsm_pkg.sv =====
// ============================================================================
// thsm_pkg
// Shared types and constants of the terrain height stencil block.
// ============================================================================
`default_nettype none

package thsm_pkg;

   localparam int CSR_DATA_W = 11;

   localparam logic CSR_FRAME_WIDTH      = 1'b0;
   localparam logic CSR_ACCESS_THRESHOLD = 1'b1;

   localparam logic [10:0] FRAME_WIDTH_RST      = 11'd256;
   localparam logic [7:0]  ACCESS_THRESHOLD_RST = 8'd27;

   // floor(x / 9) = (x * 7282) >> 16 for x up to 2295
   localparam logic [12:0] DIV9_MUL   = 13'd7282;
   localparam int          DIV9_SHIFT = 16;

   localparam int OUT_DEPTH = 8;
   localparam int OUT_PTR_W = 3;

   typedef struct packed {
      logic       mode;
      logic [7:0] height;
      logic       ramp;
   } req_type;

   typedef struct packed {
      logic [7:0] slope;
      logic       accessible;
      logic       passable;
      logic [7:0] blended_height;
      logic [7:0] sharpened_height;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/terrain_height_stencil_maps_top.sv =====
// ============================================================================
// terrain_height_stencil_maps_top
// Streaming 3x3 stencil over raster height pixels: slope, access flags,
// blended height (box blur if the center is a ramp) and sharpened height per center pixel.
// ============================================================================
//
//  port group | dir | handshake          | item
//  req_*      | in  | req_valid/req_stall | pixel or flush item (req_type)
//  rsp_*      | out | rsp_valid/rsp_stall | stencil result (rsp_type)
//  csr_*      | in  | csr_write_enable    | register write, no wait
//
//  One item per cycle while req_stall is low. The line store is one memory
//  with one read and one write per cycle; a read of the column written in
//  the same cycle is forwarded. A result passes stages 1, 2 and 3 and is
//  then written into the output queue. req_stall rises when all 8 queue
//  slots are claimed by results still in flight or waiting. Reset is
//  synchronous; the line store is not cleared.
//
`default_nettype none

module terrain_height_stencil_maps_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire thsm_pkg::req_type                   req_payload,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      thsm_pkg::rsp_type                   rsp_payload,
   input  wire logic                                csr_write_enable,
   input  wire logic                                csr_index,
   input  wire logic [thsm_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import thsm_pkg::*;

   localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
   localparam int ADDR_W = $clog2(MAX_WIDTH);
   localparam int PEND_W = $clog2(MAX_WIDTH + 2);
   localparam int USED_W = OUT_PTR_W + 1;

   // configuration
   logic [10:0] frame_width_ff;
   logic [7:0]  threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= FRAME_WIDTH_RST;
         threshold_ff   <= ACCESS_THRESHOLD_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH:      frame_width_ff <= csr_wdata;
            CSR_ACCESS_THRESHOLD: threshold_ff   <= csr_wdata[7:0];
            default:              ;
         endcase
      end
   end

   // stage 0: position control, line store read
   logic [CNT_W-1:0]  col_ff, col_in;
   logic [1:0]        rows_ff, rows_in;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [USED_W-1:0] used_ff, used_in;

   logic [CNT_W-1:0] w;
   logic             req_acc;
   logic             flush;
   logic             drop;
   logic [CNT_W-1:0] c0, c1, cc;
   logic [1:0]       rs0, rs1;
   logic [8:0]       incoming;
   logic             emit;
   logic             restart;
   logic [PEND_W-1:0] pend_step;
   logic             rd_en;

   assign req_acc = req_valid && !req_stall;

   always_comb begin
      if (frame_width_ff == 11'd0) begin
         w = CNT_W'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         w = CNT_W'(MAX_WIDTH);
      end else begin
         w = CNT_W'(frame_width_ff);
      end

      flush = req_payload.mode;
      if (col_ff >= w) begin
         c0  = '0;
         rs0 = rows_ff[1] ? rows_ff : rows_ff + 2'd1;
      end else begin
         c0  = col_ff;
         rs0 = rows_ff;
      end
      drop     = flush && (pend_ff == '0);
      incoming = flush ? 9'd0 : {req_payload.ramp, req_payload.height};
      emit     = rs0[1] || (rs0 == 2'd1 && c0 != '0);
      cc       = (c0 == '0) ? w - CNT_W'(1) : c0 - CNT_W'(1);

      c1  = c0 + CNT_W'(1);
      rs1 = rs0;
      if (c1 >= w) begin
         c1  = '0;
         rs1 = rs0[1] ? rs0 : rs0 + 2'd1;
      end
      restart   = 1'b0;
      pend_step = pend_ff;
      if (!emit && !flush) begin
         pend_step = pend_ff + PEND_W'(1);
      end else if (emit && flush) begin
         pend_step = pend_ff - PEND_W'(1);
         if (pend_ff == PEND_W'(1)) begin
            restart = 1'b1;
            c1      = '0;
            rs1     = 2'd0;
         end
      end

      col_in  = col_ff;
      rows_in = rows_ff;
      pend_in = pend_ff;
      if (req_acc) begin
         if (drop) begin
            col_in  = c0;
            rows_in = rs0;
         end else begin
            col_in  = c1;
            rows_in = rs1;
            pend_in = pend_step;
         end
      end
      rd_en = req_acc && !drop;
   end

   // stage 1 registers
   logic              s1_valid_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [8:0]        s1_incoming_ff;
   logic [1:0]        s1_rows_ff;
   logic              s1_emit_ff;
   logic [CNT_W-1:0]  s1_cc_ff;
   logic              s1_restart_ff;
   logic              s1_fwd_ff;
   logic [17:0]       fwd_data_ff;
   logic [17:0]       rd_data_ff;
   logic [17:0]       line_mem [MAX_WIDTH];

   logic [17:0] line_word;
   logic [8:0]  older, newer;
   logic [17:0] wr_data;

   always_comb begin
      line_word = s1_fwd_ff ? fwd_data_ff : rd_data_ff;
      older     = s1_rows_ff[1] ? line_word[17:9] : 9'd0;
      newer     = (s1_rows_ff != 2'd0) ? line_word[8:0] : 9'd0;
      wr_data   = {newer, s1_incoming_ff};
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_mem[s1_addr_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[c0[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_addr_ff     <= c0[ADDR_W-1:0];
         s1_incoming_ff <= incoming;
         s1_rows_ff     <= rs0;
         s1_emit_ff     <= emit;
         s1_cc_ff       <= cc;
         s1_restart_ff  <= restart;
         s1_fwd_ff      <= s1_valid_ff && (s1_addr_ff == c0[ADDR_W-1:0]);
         fwd_data_ff    <= wr_data;
      end
   end

   // window, shifted by stage 1
   logic [8:0] win_ff [3][3];
   logic       win_clr_ff;
   logic [8:0] base [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            base[r][c] = win_clr_ff ? 9'd0 : win_ff[r][c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= 9'd0;
            end
         end
         win_clr_ff <= 1'b0;
      end else if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= base[r][1];
            win_ff[r][1] <= base[r][2];
         end
         win_ff[0][2] <= older;
         win_ff[1][2] <= newer;
         win_ff[2][2] <= s1_incoming_ff;
         win_clr_ff   <= s1_restart_ff;
      end
   end

   // stage 2: neighborhood statistics
   logic             s2_valid_ff;
   logic [CNT_W-1:0] s2_cc_ff;

   always_ff @(posedge clock) begin
      s2_cc_ff <= s1_cc_ff;
   end

   logic              has_l, has_r;
   logic [7:0]        h [3][3];
   logic [7:0]        d_t, d_b, d_l, d_r, slope_c;
   logic [11:0]       sum_c;
   logic signed [11:0] detail_c;

   always_comb begin
      has_l = s2_cc_ff != '0;
      has_r = (s2_cc_ff + CNT_W'(1)) < w;
      for (int r = 0; r < 3; r++) begin
         h[r][0] = has_l ? win_ff[r][0][7:0] : 8'd0;
         h[r][1] = win_ff[r][1][7:0];
         h[r][2] = has_r ? win_ff[r][2][7:0] : 8'd0;
      end
      d_t = (h[1][1] > h[0][1]) ? h[1][1] - h[0][1] : h[0][1] - h[1][1];
      d_b = (h[1][1] > h[2][1]) ? h[1][1] - h[2][1] : h[2][1] - h[1][1];
      d_l = (h[1][1] > h[1][0]) ? h[1][1] - h[1][0] : h[1][0] - h[1][1];
      d_r = (h[1][1] > h[1][2]) ? h[1][1] - h[1][2] : h[1][2] - h[1][1];
      slope_c = d_t;
      if (d_b > slope_c) slope_c = d_b;
      if (d_l > slope_c) slope_c = d_l;
      if (d_r > slope_c) slope_c = d_r;
      sum_c = '0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            sum_c = sum_c + 12'(h[r][c]);
         end
      end
      detail_c = $signed(12'(h[1][1]) * 12'd5) - $signed(12'(h[0][1]))
                 - $signed(12'(h[2][1])) - $signed(12'(h[1][0]))
                 - $signed(12'(h[1][2]));
   end

   // stage 3: final arithmetic into the output queue
   logic               s3_valid_ff;
   logic [7:0]         s3_slope_ff;
   logic [11:0]        s3_sum_ff;
   logic signed [11:0] s3_detail_ff;
   logic [7:0]         s3_ctr_ff;
   logic               s3_ramp_ff;

   always_ff @(posedge clock) begin
      s3_slope_ff  <= slope_c;
      s3_sum_ff    <= sum_c;
      s3_detail_ff <= detail_c;
      s3_ctr_ff    <= h[1][1];
      s3_ramp_ff   <= win_ff[1][1][8];
   end

   logic [24:0]        blur_prod;
   logic signed [11:0] detail_q;
   logic signed [9:0]  sharp_s;
   rsp_type            result;

   always_comb begin
      blur_prod = 25'(s3_sum_ff) * 25'(DIV9_MUL);
      // truncate toward zero
      detail_q  = (s3_detail_ff + (s3_detail_ff[11] ? 12'sd15 : 12'sd0)) >>> 4;
      sharp_s   = $signed({2'b00, s3_ctr_ff}) + 10'(detail_q);
      result.slope      = s3_slope_ff;
      result.accessible = s3_slope_ff <= threshold_ff;
      result.passable   = result.accessible || s3_ramp_ff;
      result.blended_height = s3_ramp_ff ? blur_prod[DIV9_SHIFT +: 8] : s3_ctr_ff;
      if (sharp_s < 0) begin
         result.sharpened_height = 8'd0;
      end else if (sharp_s > 10'sd255) begin
         result.sharpened_height = 8'd255;
      end else begin
         result.sharpened_height = sharp_s[7:0];
      end
   end

   // output queue
   rsp_type              out_mem [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [USED_W-1:0]    out_cnt_ff;
   logic                 rsp_acc;

   assign rsp_valid   = out_cnt_ff != '0;
   assign rsp_payload = out_mem[rd_ptr_ff];
   assign rsp_acc     = rsp_valid && !rsp_stall;
   assign req_stall   = used_ff >= USED_W'(OUT_DEPTH);

   always_ff @(posedge clock) begin
      if (s3_valid_ff) begin
         out_mem[wr_ptr_ff] <= result;
      end
   end

   always_comb begin
      used_in = used_ff;
      if (req_acc && !drop && emit) used_in = used_in + USED_W'(1);
      if (rsp_acc)                  used_in = used_in - USED_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         rows_ff     <= '0;
         pend_ff     <= '0;
         used_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         out_cnt_ff  <= '0;
      end else begin
         col_ff      <= col_in;
         rows_ff     <= rows_in;
         pend_ff     <= pend_in;
         used_ff     <= used_in;
         s1_valid_ff <= rd_en;
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
         s3_valid_ff <= s2_valid_ff;
         if (s3_valid_ff) wr_ptr_ff <= wr_ptr_ff + OUT_PTR_W'(1);
         if (rsp_acc)     rd_ptr_ff <= rd_ptr_ff + OUT_PTR_W'(1);
         out_cnt_ff <= out_cnt_ff + USED_W'(s3_valid_ff) - USED_W'(rsp_acc);
      end
   end

   // checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= USED_W'(OUT_DEPTH))
      else $error("reserved result slots exceed queue depth");

   a_queue_within_reserve: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff <= used_ff)
      else $error("queue holds more results than reserved");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (out_cnt_ff < USED_W'(OUT_DEPTH)) || rsp_acc)
      else $error("result written into a full queue");

   a_fwd_same_col: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_fwd_ff) |-> $past(s1_valid_ff) && $past(s1_addr_ff) == s1_addr_ff)
      else $error("forwarded line data from a different column");

endmodule

`default_nettype wire
